// File: src/qfd_pkg.sv
// ---------------------------------------------------------------------------
// qfd_pkg
// Shared types, constants and arctangent tables for the quadrature FM
// demodulator.
// ---------------------------------------------------------------------------
package qfd_pkg;

  localparam int TABLE_SIZE      = 256;
  localparam int TBL_IDX_W       = 8;
  localparam int ATAN_W          = 30;
  localparam int DIFF_W          = 23;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_SHIFT     = 30 - ANGLE_FRAC_BITS;
  localparam int OUT_W           = 17;
  localparam int ANG_W           = 35;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = 2;
  localparam int QUEUE_CNT_W     = 3;
  localparam int DIV_STEPS       = 64;

  localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 35'sd6746518852;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SETUP,
    ST_DIV,
    ST_POST,
    ST_MUL,
    ST_LOAD2,
    ST_FIN
  } back_state_t;

  typedef logic [31:0]         nano_tbl_t [TABLE_SIZE];
  typedef logic [ATAN_W-1:0]   atan_tbl_t [TABLE_SIZE];
  typedef logic [DIFF_W-1:0]   diff_tbl_t [TABLE_SIZE];

  // atan(k/255) in units of 1e-9 rad
  localparam nano_tbl_t ATAN_NANO = '{
    32'd0, 32'd3921549, 32'd7842976, 32'd11764160, 32'd15684990, 32'd19605330,
    32'd23525070, 32'd27444090, 32'd31362260, 32'd35279470, 32'd39195600,
    32'd43110530, 32'd47024130, 32'd50936290, 32'd54846900, 32'd58755820,
    32'd62662950, 32'd66568160, 32'd70471340, 32'd74372380, 32'd78271140,
    32'd82167520, 32'd86061410, 32'd89952670, 32'd93841210, 32'd97726910,
    32'd101609600, 32'd105489300, 32'd109365800, 32'd113239000, 32'd117108700,
    32'd120975000, 32'd124837600, 32'd128696500, 32'd132551500, 32'd136402600,
    32'd140249600, 32'd144092400, 32'd147931000, 32'd151765200, 32'd155594800,
    32'd159419900, 32'd163240300, 32'd167055900, 32'd170866500, 32'd174672200,
    32'd178472800, 32'd182268100, 32'd186058200, 32'd189842800, 32'd193622000,
    32'd197395600, 32'd201163400, 32'd204925500, 32'd208681800, 32'd212432000,
    32'd216176200, 32'd219914300, 32'd223646100, 32'd227371600, 32'd231090700,
    32'd234803300, 32'd238509300, 32'd242208600, 32'd245901200, 32'd249586900,
    32'd253265800, 32'd256937600, 32'd260602400, 32'd264260000, 32'd267910400,
    32'd271553500, 32'd275189200, 32'd278817500, 32'd282438300, 32'd286051400,
    32'd289656900, 32'd293254700, 32'd296844700, 32'd300426800, 32'd304000900,
    32'd307567100, 32'd311125200, 32'd314675200, 32'd318217000, 32'd321750600,
    32'd325275800, 32'd328792700, 32'd332301200, 32'd335801200, 32'd339292600,
    32'd342775500, 32'd346249700, 32'd349715300, 32'd353172100, 32'd356620100,
    32'd360059300, 32'd363489600, 32'd366911000, 32'd370323400, 32'd373726800,
    32'd377121100, 32'd380506400, 32'd383882500, 32'd387249400, 32'd390607000,
    32'd393955500, 32'd397294600, 32'd400624400, 32'd403944800, 32'd407255800,
    32'd410557400, 32'd413849600, 32'd417132200, 32'd420405400, 32'd423668900,
    32'd426922900, 32'd430167300, 32'd433402100, 32'd436627200, 32'd439842600,
    32'd443048300, 32'd446244300, 32'd449430600, 32'd452607000, 32'd455773800,
    32'd458930700, 32'd462077800, 32'd465215000, 32'd468342400, 32'd471460000,
    32'd474567600, 32'd477665400, 32'd480753200, 32'd483831200, 32'd486899200,
    32'd489957300, 32'd493005500, 32'd496043700, 32'd499071900, 32'd502090200,
    32'd505098500, 32'd508096800, 32'd511085200, 32'd514063600, 32'd517032000,
    32'd519990400, 32'd522938800, 32'd525877200, 32'd528805600, 32'd531724100,
    32'd534632500, 32'd537531000, 32'd540419500, 32'd543298000, 32'd546166600,
    32'd549025100, 32'd551873800, 32'd554712400, 32'd557541100, 32'd560359900,
    32'd563168700, 32'd565967600, 32'd568756600, 32'd571535700, 32'd574304800,
    32'd577064100, 32'd579813500, 32'd582553100, 32'd585282800, 32'd588002600,
    32'd590712600, 32'd593412800, 32'd596103200, 32'd598783900, 32'd601454700,
    32'd604115800, 32'd606767200, 32'd609408800, 32'd612040700, 32'd614663000,
    32'd617275500, 32'd619878400, 32'd622471700, 32'd625055400, 32'd627629400,
    32'd630193900, 32'd632748800, 32'd635294200, 32'd637830100, 32'd640356500,
    32'd642873400, 32'd645380800, 32'd647878800, 32'd650367400, 32'd652846600,
    32'd655316500, 32'd657777000, 32'd660228200, 32'd662670100, 32'd665102700,
    32'd667526100, 32'd669940200, 32'd672345200, 32'd674740900, 32'd677127600,
    32'd679505100, 32'd681873500, 32'd684232800, 32'd686583100, 32'd688924400,
    32'd691256700, 32'd693580000, 32'd695894300, 32'd698199800, 32'd700496400,
    32'd702784100, 32'd705063000, 32'd707333000, 32'd709594300, 32'd711846900,
    32'd714090700, 32'd716325800, 32'd718552300, 32'd720770100, 32'd722979400,
    32'd725180000, 32'd727372100, 32'd729555700, 32'd731730700, 32'd733897400,
    32'd736055500, 32'd738205300, 32'd740346700, 32'd742479700, 32'd744604500,
    32'd746720900, 32'd748829100, 32'd750929100, 32'd753020800, 32'd755104400,
    32'd757179800, 32'd759247200, 32'd761306400, 32'd763357600, 32'd765400800,
    32'd767436000, 32'd769463300, 32'd771482600, 32'd773494000, 32'd775497500,
    32'd777493200, 32'd779481100, 32'd781461200, 32'd783433500, 32'd785398300
  };

  function automatic atan_tbl_t build_atan();
    atan_tbl_t   t;
    logic [63:0] v;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      v    = 64'(ATAN_NANO[k]);
      t[k] = ATAN_W'((v * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
    end
    return t;
  endfunction

  localparam atan_tbl_t ATAN_TBL = build_atan();

  function automatic diff_tbl_t build_diff();
    diff_tbl_t d;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      if (k < TABLE_SIZE - 1) begin
        d[k] = DIFF_W'(ATAN_TBL[k + 1] - ATAN_TBL[k]);
      end else begin
        d[k] = '0;
      end
    end
    return d;
  endfunction

  localparam diff_tbl_t ATAN_DIFF = build_diff();

endpackage

// File: src/qfd_front.sv
// ---------------------------------------------------------------------------
// qfd_front
// Sample intake: keeps the previous sample, forms the product with its
// conjugate in registers and pushes it to the queue.
// ---------------------------------------------------------------------------
module qfd_front #(
  parameter int SW = 16,
  parameter int PW = 2 * SW + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [SW-1:0] in_sample_i,
  input  logic signed [SW-1:0] in_sample_q,
  input  logic                 in_packet_start,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [2*PW-1:0]      q_word
);

  logic signed [SW-1:0]   prev_i_r, prev_i_nxt;
  logic signed [SW-1:0]   prev_q_r, prev_q_nxt;
  logic                   have_prev_r, have_prev_nxt;
  logic                   p_valid_r, p_valid_nxt;
  logic signed [2*SW-1:0] pii_r, pqq_r, pqi_r, piq_r;
  logic                   accept, make;
  logic signed [PW-1:0]   x, y;

  assign q_push   = p_valid_r && !q_full;
  assign in_ready = !p_valid_r || q_push;
  assign accept   = in_valid && in_ready;
  assign make     = accept && !in_packet_start && have_prev_r;

  assign x = $signed({pii_r[2*SW-1], pii_r}) + $signed({pqq_r[2*SW-1], pqq_r});
  assign y = $signed({pqi_r[2*SW-1], pqi_r}) - $signed({piq_r[2*SW-1], piq_r});
  assign q_word = {x, y};

  always_comb begin
    prev_i_nxt    = prev_i_r;
    prev_q_nxt    = prev_q_r;
    have_prev_nxt = have_prev_r;
    p_valid_nxt   = q_push ? 1'b0 : p_valid_r;
    if (accept) begin
      prev_i_nxt    = in_sample_i;
      prev_q_nxt    = in_sample_q;
      have_prev_nxt = 1'b1;
    end
    if (make) begin
      p_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_i_r    <= '0;
      prev_q_r    <= '0;
      have_prev_r <= 1'b0;
      p_valid_r   <= 1'b0;
    end else begin
      prev_i_r    <= prev_i_nxt;
      prev_q_r    <= prev_q_nxt;
      have_prev_r <= have_prev_nxt;
      p_valid_r   <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (make) begin
      pii_r <= in_sample_i * prev_i_r;
      pqq_r <= in_sample_q * prev_q_r;
      pqi_r <= in_sample_q * prev_i_r;
      piq_r <= in_sample_i * prev_q_r;
    end
  end

endmodule

// File: src/qfd_queue.sv
// ---------------------------------------------------------------------------
// qfd_queue
// Short first-in first-out queue of conjugate products between the intake
// and the phase engine.
// ---------------------------------------------------------------------------
module qfd_queue #(
  parameter int W = 66
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_word,
  output logic         full,
  input  logic         pop,
  output logic         rd_valid,
  output logic [W-1:0] rd_word
);

  logic [W-1:0]                        mem_r [qfd_pkg::QUEUE_DEPTH];
  logic [qfd_pkg::QUEUE_PTR_W-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [qfd_pkg::QUEUE_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                                do_pop;

  function automatic logic [qfd_pkg::QUEUE_CNT_W-1:0] QCW1(input logic b);
    return {{(qfd_pkg::QUEUE_CNT_W-1){1'b0}}, b};
  endfunction

  assign full     = cnt_r == qfd_pkg::QUEUE_CNT_W'(qfd_pkg::QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_word  = mem_r[rp_r];
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QCW1(push) - QCW1(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_word;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || do_pop)
    else $error("queue write while full");
`endif

endmodule

// File: src/qfd_back.sv
// ---------------------------------------------------------------------------
// qfd_back
// Phase engine: table arctangent of one conjugate product using a shared
// restoring divider and a shift-add multiplier, then quadrant fix-up and
// rounding into the output register.
// ---------------------------------------------------------------------------
module qfd_back #(
  parameter int PW = 33
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pos_range,
  input  logic                              q_valid,
  input  logic [2*PW-1:0]                   q_word,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qfd_pkg::OUT_W-1:0]  out_phase_step
);

  localparam int MW = (PW > 34) ? PW : 34;

  qfd_pkg::back_state_t st_r, st_nxt;

  logic [MW-1:0]                     s_r, s_nxt, l_r, l_nxt;
  logic                              gt_r, gt_nxt, xnn_r, xnn_nxt, ynn_r, ynn_nxt;
  logic                              zero_r, zero_nxt, br1_r, br1_nxt, pass_r, pass_nxt;
  logic [63:0]                       dvd_r, dvd_nxt, mpl_r, mpl_nxt, acc_r, acc_nxt;
  logic [33:0]                       dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [5:0]                        cnt_r, cnt_nxt;
  logic [qfd_pkg::ATAN_W-1:0]        a_r, a_nxt;
  logic [qfd_pkg::DIFF_W-1:0]        dsh_r, dsh_nxt;
  logic [30:0]                       base_r, base_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [qfd_pkg::OUT_W-1:0]         out_r, out_nxt;

  logic signed [PW-1:0]              x, y;
  logic [PW-1:0]                     ax_p, ay_p;
  logic [MW-1:0]                     ax, ay;
  logic [32:0]                       s33, l33;
  logic [40:0]                       s255;
  logic                              br1;
  logic [34:0]                       rsh, rsub;
  logic                              ge;
  logic                              idx_big;
  logic [qfd_pkg::TBL_IDX_W-1:0]     idx;
  logic signed [qfd_pkg::ANG_W-1:0]  b, ang, angp, rsum;
  logic                              fin_go;

  assign x    = q_word[2*PW-1:PW];
  assign y    = q_word[PW-1:0];
  assign ax_p = x[PW-1] ? (~x + 1'b1) : x;
  assign ay_p = y[PW-1] ? (~y + 1'b1) : y;
  assign ax   = MW'(ax_p);
  assign ay   = MW'(ay_p);

  assign s33  = s_r[32:0];
  assign l33  = l_r[32:0];
  assign s255 = {s33, 8'b0} - {8'b0, s33};
  assign br1  = s255 < {8'b0, l33};

  assign rsh  = {rem_r, dvd_r[63]};
  assign ge   = rsh >= {1'b0, dvs_r};
  assign rsub = rsh - {1'b0, dvs_r};

  assign idx_big = |dvd_r[63:qfd_pkg::TBL_IDX_W];
  assign idx     = idx_big ? '1 : dvd_r[qfd_pkg::TBL_IDX_W-1:0];

  assign b = $signed({4'b0, base_r});

  always_comb begin
    if (zero_r) begin
      ang = '0;
    end else if (gt_r) begin
      if (xnn_r) begin
        ang = ynn_r ? b : -b;
      end else begin
        ang = ynn_r ? qfd_pkg::Q30_PI - b : b - qfd_pkg::Q30_PI;
      end
    end else begin
      if (ynn_r) begin
        ang = xnn_r ? qfd_pkg::Q30_HALF_PI - b : qfd_pkg::Q30_HALF_PI + b;
      end else begin
        ang = xnn_r ? b - qfd_pkg::Q30_HALF_PI : -qfd_pkg::Q30_HALF_PI - b;
      end
    end
    angp = (pos_range && ang[qfd_pkg::ANG_W-1]) ? ang + qfd_pkg::Q30_TWO_PI : ang;
    rsum = angp + $signed(qfd_pkg::ANG_W'(1) << (qfd_pkg::ANGLE_SHIFT - 1));
  end

  assign fin_go = (st_r == qfd_pkg::ST_FIN) && (!out_valid_r || out_ready);
  assign q_pop  = (st_r == qfd_pkg::ST_IDLE) && q_valid;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      qfd_pkg::ST_IDLE: begin
        if (q_valid) begin
          st_nxt = (x == '0 && y == '0) ? qfd_pkg::ST_FIN : qfd_pkg::ST_NORM;
        end
      end
      qfd_pkg::ST_NORM: begin
        if (!(|l_r[MW-1:33])) begin
          st_nxt = qfd_pkg::ST_SETUP;
        end
      end
      qfd_pkg::ST_SETUP: st_nxt = qfd_pkg::ST_DIV;
      qfd_pkg::ST_DIV: begin
        if (cnt_r == 6'(qfd_pkg::DIV_STEPS - 1)) begin
          st_nxt = qfd_pkg::ST_POST;
        end
      end
      qfd_pkg::ST_POST: begin
        st_nxt = (br1_r || pass_r) ? qfd_pkg::ST_FIN : qfd_pkg::ST_MUL;
      end
      qfd_pkg::ST_MUL: begin
        if (cnt_r == 6'(qfd_pkg::DIFF_W - 1)) begin
          st_nxt = qfd_pkg::ST_LOAD2;
        end
      end
      qfd_pkg::ST_LOAD2: st_nxt = qfd_pkg::ST_DIV;
      qfd_pkg::ST_FIN: begin
        if (fin_go) begin
          st_nxt = qfd_pkg::ST_IDLE;
        end
      end
      default: st_nxt = qfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_nxt    = s_r;
    l_nxt    = l_r;
    gt_nxt   = gt_r;
    xnn_nxt  = xnn_r;
    ynn_nxt  = ynn_r;
    zero_nxt = zero_r;
    br1_nxt  = br1_r;
    pass_nxt = pass_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    dsh_nxt  = dsh_r;
    mpl_nxt  = mpl_r;
    acc_nxt  = acc_r;
    base_nxt = base_r;
    out_nxt  = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    case (st_r)
      qfd_pkg::ST_IDLE: begin
        gt_nxt   = ax > ay;
        s_nxt    = (ax > ay) ? ay : ax;
        l_nxt    = (ax > ay) ? ax : ay;
        xnn_nxt  = !x[PW-1];
        ynn_nxt  = !y[PW-1];
        zero_nxt = (x == '0) && (y == '0);
      end
      qfd_pkg::ST_NORM: begin
        if (|l_r[MW-1:33]) begin
          s_nxt = s_r >> 1;
          l_nxt = l_r >> 1;
        end
      end
      qfd_pkg::ST_SETUP: begin
        br1_nxt  = br1;
        pass_nxt = 1'b0;
        cnt_nxt  = '0;
        rem_nxt  = '0;
        if (br1) begin
          dvd_nxt = 64'({s33, 30'b0}) + 64'(l33 >> 1);
          dvs_nxt = {1'b0, l33};
        end else begin
          dvd_nxt = 64'({s33, 9'b0}) - 64'(l33);
          dvs_nxt = {l33, 1'b0};
        end
      end
      qfd_pkg::ST_DIV: begin
        rem_nxt = ge ? rsub[33:0] : rsh[33:0];
        dvd_nxt = {dvd_r[62:0], ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      qfd_pkg::ST_POST: begin
        if (br1_r) begin
          base_nxt = dvd_r[30:0];
        end else if (pass_r) begin
          base_nxt = {1'b0, a_r} + dvd_r[30:0];
        end else begin
          a_nxt   = qfd_pkg::ATAN_TBL[idx];
          dsh_nxt = qfd_pkg::ATAN_DIFF[idx];
          mpl_nxt = idx_big ? '0 : 64'(rem_r);
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
      qfd_pkg::ST_MUL: begin
        acc_nxt = acc_r + (dsh_r[0] ? mpl_r : 64'd0);
        mpl_nxt = mpl_r << 1;
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
      end
      qfd_pkg::ST_LOAD2: begin
        dvd_nxt  = acc_r + 64'(l33);
        dvs_nxt  = {l33, 1'b0};
        rem_nxt  = '0;
        cnt_nxt  = '0;
        pass_nxt = 1'b1;
      end
      qfd_pkg::ST_FIN: begin
        if (fin_go) begin
          out_nxt       = rsum[qfd_pkg::ANGLE_SHIFT+qfd_pkg::OUT_W-1:qfd_pkg::ANGLE_SHIFT];
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= qfd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    l_r    <= l_nxt;
    gt_r   <= gt_nxt;
    xnn_r  <= xnn_nxt;
    ynn_r  <= ynn_nxt;
    zero_r <= zero_nxt;
    br1_r  <= br1_nxt;
    pass_r <= pass_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    a_r    <= a_nxt;
    dsh_r  <= dsh_nxt;
    mpl_r  <= mpl_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_phase_step = out_r;

`ifndef ASSERT_OFF
  a_small_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == qfd_pkg::ST_POST) && br1_r |-> dvd_r[63:30] == '0)
    else $error("small-ratio quotient out of range");
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == qfd_pkg::ST_POST) && !br1_r && !pass_r |-> !idx_big)
    else $error("table index out of range");
  a_interp: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == qfd_pkg::ST_POST) && pass_r |-> dvd_r[63:qfd_pkg::DIFF_W] == '0)
    else $error("interpolation term too large");
`endif

endmodule

// File: src/quadrature_fm_demodulator.sv
// ---------------------------------------------------------------------------
// quadrature_fm_demodulator
// FM quadrature discriminator: phase of each sample times the conjugate of
// the previous one, via a table arctangent, in radians scaled by 8192.
// ---------------------------------------------------------------------------
// Samples are taken one per clock, while there is room, into a four-word queue.
// The phase engine halves the product magnitudes until the larger is below
// 2^33, then runs a 64-step restoring divider once if the small-to-large
// ratio is below 1/255, else twice with a 23-step shift-add multiply between;
// a zero product skips all that. The divider sets the sustained rate. The
// first sample of a packet yields no word. The user must write positive_range
// through the cfg port only while idle; the block itself does not enforce it.
module quadrature_fm_demodulator #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_q,
  input  logic                              in_packet_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qfd_pkg::OUT_W-1:0]  out_phase_step,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_positive_range
);

  localparam int PW = 2 * SAMPLE_WIDTH + 1;

  logic              pos_range_r, pos_range_nxt;
  logic              q_full, q_push, q_pop, q_valid;
  logic [2*PW-1:0]   q_wr_word, q_rd_word;

  assign cfg_ready     = 1'b1;
  assign pos_range_nxt = (cfg_valid && cfg_ready) ? cfg_positive_range : pos_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_range_r <= 1'b0;
    end else begin
      pos_range_r <= pos_range_nxt;
    end
  end

  qfd_front #(.SW(SAMPLE_WIDTH), .PW(PW)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_i     (in_sample_i),
    .in_sample_q     (in_sample_q),
    .in_packet_start (in_packet_start),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_word          (q_wr_word)
  );

  qfd_queue #(.W(2 * PW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_word  (q_wr_word),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_word  (q_rd_word)
  );

  qfd_back #(.PW(PW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pos_range      (pos_range_r),
    .q_valid        (q_valid),
    .q_word         (q_rd_word),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_phase_step (out_phase_step)
  );

endmodule

// File: bench/quadrature_fm_demodulator_tb.sv
// ---------------------------------------------------------------------------
// quadrature_fm_demodulator_tb
// Drives I/Q samples and packet starts into the demodulator under several
// idle and stall patterns and compares every phase word with a predictor.
// ---------------------------------------------------------------------------
module quadrature_fm_demodulator_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  class phase_scoreboard;
    logic signed [qfd_pkg::OUT_W-1:0] pending_q[$];
    longint prev_i, prev_q;
    bit     have_prev;
    bit     pos_range;
    longint atan_q30[qfd_pkg::TABLE_SIZE+1];
    int     errors;
    int     matched;

    function new();
      longint a;
      for (int k = 0; k < qfd_pkg::TABLE_SIZE; k++) begin
        a = (longint'(qfd_pkg::ATAN_NANO[k]) * 64'd1073741824 + 64'd500000000)
            / 64'd1000000000;
        atan_q30[k] = a;
      end
      atan_q30[qfd_pkg::TABLE_SIZE] = atan_q30[qfd_pkg::TABLE_SIZE-1];
      errors = 0;
      matched = 0;
      have_prev = 0;
      pos_range = 0;
      prev_i = 0;
      prev_q = 0;
    endfunction

    function longint phase_q30(longint x, longint y);
      longint ax, ay, s, l, base, num, den, idx, rem, d, ang;
      if (x == 0 && y == 0) return 0;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      if (ay < ax) begin
        s = ay; l = ax;
      end else begin
        s = ax; l = ay;
      end
      while (l >= (64'sd1 << 33)) begin
        s = s >>> 1;
        l = l >>> 1;
      end
      if (s * (qfd_pkg::TABLE_SIZE - 1) < l) begin
        base = ((s <<< 30) + l / 2) / l;
      end else begin
        num = 2 * s * qfd_pkg::TABLE_SIZE - l;
        den = 2 * l;
        idx = num / den;
        rem = num % den;
        if (idx > qfd_pkg::TABLE_SIZE - 1) begin
          idx = qfd_pkg::TABLE_SIZE - 1;
          rem = 0;
        end
        d = atan_q30[idx+1] - atan_q30[idx];
        base = atan_q30[idx] + (d * rem + l) / den;
      end
      if (ax > ay) begin
        if (x >= 0) ang = (y >= 0) ? base : -base;
        else ang = (y >= 0) ? longint'(qfd_pkg::Q30_PI) - base
                            : base - longint'(qfd_pkg::Q30_PI);
      end else begin
        if (y >= 0) ang = (x >= 0) ? longint'(qfd_pkg::Q30_HALF_PI) - base
                                   : longint'(qfd_pkg::Q30_HALF_PI) + base;
        else ang = (x >= 0) ? -longint'(qfd_pkg::Q30_HALF_PI) + base
                            : -longint'(qfd_pkg::Q30_HALF_PI) - base;
      end
      return ang;
    endfunction

    function void note_sample(logic signed [15:0] si, logic signed [15:0] sq, bit start);
      longint re, im, ang, r;
      if (start || !have_prev) begin
        prev_i = si;
        prev_q = sq;
        have_prev = 1;
        return;
      end
      re = longint'(si) * prev_i + longint'(sq) * prev_q;
      im = longint'(sq) * prev_i - longint'(si) * prev_q;
      prev_i = si;
      prev_q = sq;
      ang = phase_q30(re, im);
      if (pos_range && ang < 0) ang += longint'(qfd_pkg::Q30_TWO_PI);
      r = (ang + (64'sd1 << (qfd_pkg::ANGLE_SHIFT - 1))) >>> qfd_pkg::ANGLE_SHIFT;
      pending_q.push_back(qfd_pkg::OUT_W'(r));
    endfunction

    function void check_phase(logic signed [qfd_pkg::OUT_W-1:0] got);
      logic signed [qfd_pkg::OUT_W-1:0] want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected phase word, actual %0d", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $display("%0t: phase mismatch, expected %0d actual %0d", $time, want, got);
        errors++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] in_sample_i = 0;
  logic signed [15:0] in_sample_q = 0;
  logic in_packet_start = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [qfd_pkg::OUT_W-1:0] out_phase_step;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_positive_range = 0;

  phase_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int samples_sent = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  quadrature_fm_demodulator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_i(in_sample_i), .in_sample_q(in_sample_q),
    .in_packet_start(in_packet_start),
    .out_valid(out_valid), .out_ready(out_ready), .out_phase_step(out_phase_step),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_positive_range(cfg_positive_range)
  );

  initial sb = new();

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_phase(out_phase_step);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq, bit start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_sample_i <= si;
    in_sample_q <= sq;
    in_packet_start <= start;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(si, sq, start);
    samples_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_range(bit val);
    cfg_valid <= 1;
    cfg_positive_range <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.pos_range = val;
    cfg_valid <= 0;
  endtask

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(32767) - 16384) >>> $urandom_range(12);
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic random_phase(int count, int idle, int stall, bit prange);
    int amp;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    drain_results();
    write_range(prange);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        send_sample(rand_comp($urandom_range(2)), rand_comp($urandom_range(2)),
                    $urandom_range(3) == 0);
      end else begin
        amp = $urandom_range(32767);
        send_sample(16'($urandom_range(2*amp) - amp), 16'($urandom_range(2*amp) - amp),
                    $urandom_range(15) == 0);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: no predecessor, extremes, zero product, equal magnitudes
    send_sample(16'sd1000, 16'sd0, 0);
    send_sample(16'sd0, 16'sd1000, 0);
    send_sample(-16'sd1000, 16'sd0, 0);
    send_sample(16'sd0, -16'sd1000, 0);
    send_sample(16'sd1000, 16'sd0, 0);
    send_sample(16'sd0, 16'sd0, 0);
    send_sample(16'sd5, 16'sd5, 0);
    send_sample(16'sh7fff, 16'sh7fff, 1);
    send_sample(16'sh8000, 16'sh8000, 0);
    send_sample(16'sh8000, 16'sh7fff, 0);
    send_sample(16'sh7fff, 16'sh8000, 0);
    send_sample(-16'sd1, 16'sd0, 0);
    send_sample(16'sd1, 16'sd0, 0);
    send_sample(16'sd30000, 16'sd10, 0);
    send_sample(16'sd30000, -16'sd10, 0);
    send_sample(-16'sd30000, 16'sd100, 0);
    send_sample(-16'sd1, -16'sd1, 1);
    drain_results();
    write_range(1);
    send_sample(16'sd1000, 16'sd0, 1);
    send_sample(16'sd0, -16'sd1000, 0);
    send_sample(-16'sd1000, 16'sd0, 0);
    send_sample(16'sd0, 16'sd1000, 0);
    send_sample(16'sd1000, -16'sd3, 0);
    random_phase(250, 0, 0, 0);
    random_phase(250, 76, 0, 1);
    random_phase(250, 0, 76, 0);
    random_phase(150, 6, 6, 1);
    drain_results();
    $display("Sent %0d samples over four idle/stall phases, both range settings.",
             samples_sent);
    $display("Checked %0d phase words.", sb.matched);
    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

// File: filelist.f
src/qfd_pkg.sv
src/qfd_front.sv
src/qfd_queue.sv
src/qfd_back.sv
src/quadrature_fm_demodulator.sv
bench/quadrature_fm_demodulator_tb.sv
